[rtl/obsf_pkg.sv]
// obsf_pkg: shared types and constants for the occupancy bitmap slot finder
// transaction structs, request and status codes, sequencer states, word unit result
// no dependencies
package obsf_pkg;

  localparam int WORD_W   = 64;
  localparam int WORD_LSB = 6;

  localparam logic [2:0] KIND_MARK = 3'd0;
  localparam logic [2:0] KIND_FREE = 3'd1;
  localparam logic [2:0] KIND_TEST = 3'd2;
  localparam logic [2:0] KIND_FIND = 3'd3;
  localparam logic [2:0] KIND_INIT = 3'd4;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_REFUSED = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;
  localparam logic [1:0] ST_NONE    = 2'd3;

  localparam logic [9:0] MAX_ROWS_RST = 10'd512;

  typedef struct packed {
    logic [2:0] kind;
    logic [8:0] row;
    logic [9:0] range_begin;
    logic [9:0] range_end;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic       bit_value;
    logic [8:0] found_row;
    logic [9:0] occupied_count;
  } out_item_t;

  typedef struct packed {
    logic              hit;
    logic [WORD_LSB-1:0] pos;
    logic              bit_at;
  } wu_res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_FCHECK,
    S_FSCAN,
    S_OUT
  } state_t;

endpackage

[rtl/obsf_word_unit.sv]
// obsf_word_unit: shared 64-bit word unit
// windowed find-first-zero, bit select and single-bit set or clear
// depends on obsf_pkg
module obsf_word_unit (
  input  logic [obsf_pkg::WORD_W-1:0]   word,
  input  logic [obsf_pkg::WORD_LSB-1:0] lo,
  input  logic [obsf_pkg::WORD_LSB-1:0] hi,
  input  logic [obsf_pkg::WORD_LSB-1:0] sel,
  input  logic                          set_val,
  output obsf_pkg::wu_res_t             res,
  output logic [obsf_pkg::WORD_W-1:0]   word_mod
);
  import obsf_pkg::*;

  logic [WORD_W-1:0] cand;
  logic [WORD_W-1:0] onehot;

  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      cand[b] = ~word[b] && (WORD_LSB'(b) >= lo) && (WORD_LSB'(b) <= hi);
    end
  end

  // lowest set candidate bit
  always_comb begin
    res.hit    = |cand;
    res.pos    = '0;
    res.bit_at = word[sel];
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (cand[b]) begin
        res.pos = WORD_LSB'(b);
      end
    end
  end

  always_comb begin
    onehot = '0;
    onehot[sel] = 1'b1;
    word_mod = set_val ? (word | onehot) : (word & ~onehot);
  end

endmodule

[rtl/obsf_bitmap_mem.sv]
// obsf_bitmap_mem: occupancy bitmap storage, one 64-bit word per entry
// registered read, per-word valid flags cleared by reset or init
// depends on obsf_pkg
module obsf_bitmap_mem #(
  parameter int NWORDS = 8,
  parameter int AW     = 3
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        clear,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [obsf_pkg::WORD_W-1:0] wr_data,
  input  logic [AW-1:0]               rd_addr,
  output logic [obsf_pkg::WORD_W-1:0] rd_data
);
  import obsf_pkg::*;

  logic [WORD_W-1:0] mem [NWORDS];
  logic [NWORDS-1:0] vld_r;
  logic [WORD_W-1:0] rd_data_r;
  logic              rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  // an entry never written since clear reads as all free
  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

[rtl/occupancy_bitmap_slot_finder_top.sv]
// occupancy_bitmap_slot_finder_top: row occupancy bitmap with find-first-free search
// sequencer, occupied count and result register around the bitmap memory and word unit
// depends on obsf_pkg, obsf_bitmap_mem, obsf_word_unit
//
// usage: one request transaction on in_* gives one result transaction on out_*.
// in_stall is high while a request is in progress; a new request is taken while
// the previous result still waits in the output register.
// sequence: init, unused kinds and out-of-page rows go from S_IDLE straight to S_OUT;
// mark, free and test pass through S_EXEC first; find passes through S_FCHECK, which
// ends on the count or range checks or enters S_FSCAN to scan 64-bit bitmap words one
// by one (up to 8 words for 512 rows) through the bitmap memory's single read port.
// cfg_wr_en writes max_rows; write it only while no request is in progress.
// reset: bitmap reads as all free, count zero, max_rows 512, no result pending.
// init clears the bitmap through per-word valid flags.
// when out_stall holds a result, the result stays stable and a finished
// request waits for the output register before the block takes another.
module occupancy_bitmap_slot_finder_top #(
  parameter int ROWS_PER_PAGE = 512
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [9:0]           cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  obsf_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output obsf_pkg::out_item_t  out_data
);
  import obsf_pkg::*;

  localparam int RW     = $clog2(ROWS_PER_PAGE + 1);
  localparam int IW     = (RW > 10) ? RW : 10;
  localparam int NWORDS = (ROWS_PER_PAGE + WORD_W - 1) / WORD_W;
  localparam int NWI    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam logic [IW-1:0] ROWS_W = IW'(ROWS_PER_PAGE);

  state_t           state_r, state_nxt;
  in_item_t         req_r, req_nxt;
  logic [9:0]       max_rows_r;
  logic [RW-1:0]    cnt_r, cnt_nxt;
  logic [1:0]       status_r, status_nxt;
  logic             bit_r, bit_nxt;
  logic [8:0]       found_r, found_nxt;
  logic [NWI-1:0]   word_r, word_nxt;
  logic [NWI-1:0]   last_r, last_nxt;
  logic [IW-1:0]    endm1_r, endm1_nxt;
  logic             out_valid_r;
  out_item_t        out_data_r;

  logic             in_acc;
  logic             out_free;
  logic             out_load;
  logic             clear;
  logic             wr_en;
  logic [NWI-1:0]   rd_addr;
  logic [WORD_W-1:0] rd_data;
  logic [WORD_W-1:0] word_mod;
  logic [WORD_LSB-1:0] lo, hi;
  wu_res_t          wres;

  logic [IW-1:0]    lim, end_c, beg_w, in_row_w, req_row_w;
  logic             in_page_in;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign lim       = (IW'(max_rows_r) < ROWS_W) ? IW'(max_rows_r) : ROWS_W;
  assign end_c     = (IW'(req_r.range_end) > lim) ? lim : IW'(req_r.range_end);
  assign beg_w     = IW'(req_r.range_begin);
  assign in_row_w  = IW'(in_data.row);
  assign req_row_w = IW'(req_r.row);
  assign in_page_in = in_row_w < ROWS_W;

  assign lo = (word_r == NWI'(beg_w >> WORD_LSB)) ? beg_w[WORD_LSB-1:0] : '0;
  assign hi = (word_r == last_r) ? endm1_r[WORD_LSB-1:0] : '1;

  obsf_bitmap_mem #(
    .NWORDS(NWORDS),
    .AW    (NWI)
  ) u_mem (
    .clk    (clk),
    .rst_n  (rst_n),
    .clear  (clear),
    .wr_en  (wr_en),
    .wr_addr(NWI'(req_row_w >> WORD_LSB)),
    .wr_data(word_mod),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  obsf_word_unit u_wu (
    .word    (rd_data),
    .lo      (lo),
    .hi      (hi),
    .sel     (req_r.row[WORD_LSB-1:0]),
    .set_val (req_r.kind == KIND_MARK),
    .res     (wres),
    .word_mod(word_mod)
  );

  always_comb begin
    state_nxt  = state_r;
    req_nxt    = req_r;
    cnt_nxt    = cnt_r;
    status_nxt = status_r;
    bit_nxt    = bit_r;
    found_nxt  = found_r;
    word_nxt   = word_r;
    last_nxt   = last_r;
    endm1_nxt  = endm1_r;
    clear      = 1'b0;
    wr_en      = 1'b0;
    out_load   = 1'b0;
    rd_addr    = word_r;
    case (state_r)
      S_IDLE: begin
        rd_addr = NWI'(in_row_w >> WORD_LSB);
        if (in_acc) begin
          req_nxt    = in_data;
          status_nxt = ST_DONE;
          bit_nxt    = 1'b0;
          found_nxt  = '0;
          case (in_data.kind)
            KIND_MARK, KIND_FREE: begin
              if (in_page_in) begin
                state_nxt = S_EXEC;
              end else begin
                status_nxt = ST_REFUSED;
                state_nxt  = S_OUT;
              end
            end
            KIND_TEST: begin
              state_nxt = in_page_in ? S_EXEC : S_OUT;
            end
            KIND_FIND: begin
              state_nxt = S_FCHECK;
            end
            KIND_INIT: begin
              clear     = 1'b1;
              cnt_nxt   = '0;
              state_nxt = S_OUT;
            end
            default: begin
              status_nxt = ST_REFUSED;
              state_nxt  = S_OUT;
            end
          endcase
        end
      end
      S_EXEC: begin
        state_nxt = S_OUT;
        case (req_r.kind)
          KIND_MARK: begin
            if (wres.bit_at) begin
              status_nxt = ST_REFUSED;
            end else begin
              wr_en   = 1'b1;
              cnt_nxt = cnt_r + RW'(1);
            end
          end
          KIND_FREE: begin
            if (!wres.bit_at) begin
              status_nxt = ST_REFUSED;
            end else begin
              wr_en   = 1'b1;
              cnt_nxt = cnt_r - RW'(1);
            end
          end
          default: begin
            bit_nxt = wres.bit_at;
          end
        endcase
      end
      S_FCHECK: begin
        rd_addr   = NWI'(beg_w >> WORD_LSB);
        word_nxt  = NWI'(beg_w >> WORD_LSB);
        endm1_nxt = end_c - IW'(1);
        last_nxt  = NWI'((end_c - IW'(1)) >> WORD_LSB);
        if (IW'(cnt_r) == lim) begin
          status_nxt = ST_NONE;
          state_nxt  = S_OUT;
        end else if (beg_w > end_c) begin
          status_nxt = ST_RANGE;
          state_nxt  = S_OUT;
        end else if (beg_w == end_c) begin
          status_nxt = ST_NONE;
          state_nxt  = S_OUT;
        end else begin
          state_nxt = S_FSCAN;
        end
      end
      S_FSCAN: begin
        rd_addr  = word_r + NWI'(1);
        word_nxt = word_r + NWI'(1);
        if (wres.hit) begin
          found_nxt = 9'({word_r, wres.pos});
          state_nxt = S_OUT;
        end else if (word_r == last_r) begin
          status_nxt = ST_NONE;
          state_nxt  = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      max_rows_r  <= MAX_ROWS_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_wr_en) begin
        max_rows_r <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    status_r <= status_nxt;
    bit_r    <= bit_nxt;
    found_r  <= found_nxt;
    word_r   <= word_nxt;
    last_r   <= last_nxt;
    endm1_r  <= endm1_nxt;
    if (out_load) begin
      out_data_r.status         <= status_r;
      out_data_r.bit_value      <= bit_r;
      out_data_r.found_row      <= found_r;
      out_data_r.occupied_count <= 10'(cnt_r);
    end
  end

endmodule
